/* sv/mlfq_pkg.sv */
// Shared types and constants for the multilevel feedback task scheduler.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package mlfq_pkg;

    localparam int OP_W    = 3;
    localparam int TASK_W  = 6;
    localparam int LEVEL_W = 6;
    localparam int SLICE_W = 5;

    localparam int NUM_LEVELS = 40;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL   = 6'd39;
    localparam logic [LEVEL_W-1:0] DEMOTE_STEP = 6'd10;
    localparam logic [LEVEL_W-1:0] BAND_1_LOW  = 6'd10;
    localparam logic [LEVEL_W-1:0] BAND_2_LOW  = 6'd20;

    // Refill slice after a demotion, (4 - level/10) * 4 for each band of ten levels.
    localparam logic [SLICE_W-1:0] SLICE_BAND_0 = 5'd16;
    localparam logic [SLICE_W-1:0] SLICE_BAND_1 = 5'd12;
    localparam logic [SLICE_W-1:0] SLICE_BAND_2 = 5'd8;
    localparam logic [SLICE_W-1:0] SLICE_ONE    = 5'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 3'd0,
        OP_DEQUEUE = 3'd1,
        OP_YIELD   = 3'd2,
        OP_PICK    = 3'd3,
        OP_TICK    = 3'd4,
        OP_PREEMPT = 3'd5
    } t_op;

    // Level reached by a task that wakes up from sleep.
    localparam logic [LEVEL_W-1:0] BOOST_TABLE [NUM_LEVELS] = '{
        6'd30, 6'd30, 6'd30, 6'd30, 6'd30, 6'd30, 6'd30, 6'd30, 6'd30, 6'd30,
        6'd31, 6'd31, 6'd31, 6'd31, 6'd31, 6'd31, 6'd31, 6'd31, 6'd31, 6'd31,
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd36, 6'd37, 6'd37, 6'd38, 6'd38,
        6'd39, 6'd39, 6'd39, 6'd39, 6'd39, 6'd39, 6'd39, 6'd39, 6'd39, 6'd39
    };

    // Field write enables of the per-task link memory.
    typedef struct packed {
        logic next;
        logic prev;
        logic level;
    } t_task_wen;

    // Field write enables of the per-level head and tail memory.
    typedef struct packed {
        logic head;
        logic tail;
    } t_level_wen;

endpackage

`default_nettype wire

/* sv/mlfq_in_if.sv */
// Input channel of the scheduler: one request item with valid and ready.
// Depends on mlfq_pkg for field widths.
`default_nettype none

interface mlfq_in_if;
    logic                          valid;
    logic                          ready;
    logic [mlfq_pkg::OP_W-1:0]     operation;
    logic [mlfq_pkg::TASK_W-1:0]   task_id;
    logic [mlfq_pkg::LEVEL_W-1:0]  level;
    logic                          wakeup;
    logic                          is_timeshare;
    logic [mlfq_pkg::SLICE_W-1:0]  slice_left;
    logic [mlfq_pkg::LEVEL_W-1:0]  running_level;

    modport source (
        output valid, operation, task_id, level, wakeup, is_timeshare, slice_left,
               running_level,
        input  ready
    );
    modport sink (
        input  valid, operation, task_id, level, wakeup, is_timeshare, slice_left,
               running_level,
        output ready
    );
endinterface

`default_nettype wire

/* sv/mlfq_out_if.sv */
// Output channel of the scheduler: one result item with valid and ready.
// Depends on mlfq_pkg for field widths.
`default_nettype none

interface mlfq_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [mlfq_pkg::TASK_W-1:0]   chosen_task;
    logic [mlfq_pkg::LEVEL_W-1:0]  new_level;
    logic [mlfq_pkg::SLICE_W-1:0]  new_slice;
    logic                          resched;

    modport source (
        output valid, found, chosen_task, new_level, new_slice, resched,
        input  ready
    );
    modport sink (
        input  valid, found, chosen_task, new_level, new_slice, resched,
        output ready
    );
endinterface

`default_nettype wire

/* sv/mlfq_task_mem.sv */
// Per-task link memory: next link, previous link and queued level of each task.
// One read port with registered data, one write port with field enables (mlfq_pkg).
`default_nettype none

module mlfq_task_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int LW    = 7
) (
    input  wire                                i_clk,
    input  wire                                i_rd_en,
    input  wire  [AW-1:0]                      i_rd_addr,
    output logic [LW-1:0]                      o_rd_next,
    output logic [LW-1:0]                      o_rd_prev,
    output logic [mlfq_pkg::LEVEL_W-1:0]       o_rd_level,
    input  mlfq_pkg::t_task_wen                i_wr_en,
    input  wire  [AW-1:0]                      i_wr_addr,
    input  wire  [LW-1:0]                      i_wr_next,
    input  wire  [LW-1:0]                      i_wr_prev,
    input  wire  [mlfq_pkg::LEVEL_W-1:0]       i_wr_level
);

    logic [LW-1:0]                r_next_mem  [DEPTH];
    logic [LW-1:0]                r_prev_mem  [DEPTH];
    logic [mlfq_pkg::LEVEL_W-1:0] r_level_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en.next) begin
            r_next_mem[i_wr_addr] <= i_wr_next;
        end
        if (i_wr_en.prev) begin
            r_prev_mem[i_wr_addr] <= i_wr_prev;
        end
        if (i_wr_en.level) begin
            r_level_mem[i_wr_addr] <= i_wr_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_next  <= r_next_mem[i_rd_addr];
            o_rd_prev  <= r_prev_mem[i_rd_addr];
            o_rd_level <= r_level_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/mlfq_level_mem.sv */
// Per-level queue memory: head and tail task of each priority level.
// One read port with registered data, one write port with field enables (mlfq_pkg).
`default_nettype none

module mlfq_level_mem #(
    parameter int DW = 6
) (
    input  wire                                i_clk,
    input  wire                                i_rd_en,
    input  wire  [mlfq_pkg::LEVEL_W-1:0]       i_rd_addr,
    output logic [DW-1:0]                      o_rd_head,
    output logic [DW-1:0]                      o_rd_tail,
    input  mlfq_pkg::t_level_wen               i_wr_en,
    input  wire  [mlfq_pkg::LEVEL_W-1:0]       i_wr_addr,
    input  wire  [DW-1:0]                      i_wr_head,
    input  wire  [DW-1:0]                      i_wr_tail
);

    logic [DW-1:0] r_head_mem [mlfq_pkg::NUM_LEVELS];
    logic [DW-1:0] r_tail_mem [mlfq_pkg::NUM_LEVELS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en.head) begin
            r_head_mem[i_wr_addr] <= i_wr_head;
        end
        if (i_wr_en.tail) begin
            r_tail_mem[i_wr_addr] <= i_wr_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_head <= r_head_mem[i_rd_addr];
            o_rd_tail <= r_tail_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/multilevel_feedback_task_scheduler_unit.sv */
// Top level of the multilevel feedback task scheduler: sequencer, queue bitmap, result register.
// Depends on mlfq_pkg, mlfq_in_if, mlfq_out_if, mlfq_task_mem and mlfq_level_mem.
//
//   channel    direction  interface          contents
//   i_task     in         mlfq_in_if.sink    operation, task, levels, slice, flags
//   o_result   out        mlfq_out_if.source found, chosen task, new level/slice, resched
//
// An item steps through states in order: an unlink passes S_UL_RD and S_UL_WR, an append
// S_AP_WR and, when its level already holds a task, S_AP_LINK, a pick S_PK_RD; all end in
// S_FIN. This sequence is set by the single write port of the task link memory, through which the
// neighbor links of an unlink and the tail link of an append go one after the other.
// Synchronous active-low reset empties all queues; no clearing pass is needed.
// A new item is taken while the previous result still waits in the output register;
// a finished item waits in its last state while that register is full.
`default_nettype none

module multilevel_feedback_task_scheduler_unit #(
    parameter int MAX_TASKS = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mlfq_in_if.sink           i_task,
    mlfq_out_if.source        o_result
);

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int LW = $clog2(MAX_TASKS + 1);
    localparam int XW = (TW > mlfq_pkg::TASK_W) ? TW : mlfq_pkg::TASK_W;
    localparam int QN = (MAX_TASKS < 64) ? MAX_TASKS : 64;
    localparam int QW = $clog2(QN);
    localparam logic [LW-1:0] NONE = LW'(MAX_TASKS);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_UL_RD   = 7'b0000010,
        S_UL_WR   = 7'b0000100,
        S_AP_WR   = 7'b0001000,
        S_AP_LINK = 7'b0010000,
        S_PK_RD   = 7'b0100000,
        S_FIN     = 7'b1000000
    } t_state;

    t_state                         r_state, n_state;
    logic [mlfq_pkg::NUM_LEVELS-1:0] r_mask;
    logic [QN-1:0]                  r_queued;

    logic [TW-1:0]                  r_idx;
    logic [mlfq_pkg::LEVEL_W-1:0]   r_alv;
    logic                           r_do_append;
    logic [LW-1:0]                  r_p, r_n;
    logic [TW-1:0]                  r_tl;

    logic                           r_res_found;
    logic [mlfq_pkg::TASK_W-1:0]    r_res_chosen;
    logic [mlfq_pkg::LEVEL_W-1:0]   r_res_level;
    logic [mlfq_pkg::SLICE_W-1:0]   r_res_slice;
    logic                           r_res_resched;

    logic                           r_out_valid;
    logic                           r_out_found;
    logic [mlfq_pkg::TASK_W-1:0]    r_out_chosen;
    logic [mlfq_pkg::LEVEL_W-1:0]   r_out_level;
    logic [mlfq_pkg::SLICE_W-1:0]   r_out_slice;
    logic                           r_out_resched;

    // ---------------------------------------------------------------- request decode
    mlfq_pkg::t_op                  in_op;
    logic [XW-1:0]                  tid_x;
    logic [TW-1:0]                  in_idx;
    logic                           in_ok;
    logic                           in_queued;
    logic [mlfq_pkg::LEVEL_W-1:0]   lv_sat, run_sat, dem_lv, in_alv;
    logic [mlfq_pkg::SLICE_W-1:0]   refill;
    logic                           expire;
    logic                           in_append, in_unlink;
    logic                           accept;
    logic [mlfq_pkg::LEVEL_W-1:0]   top_lv;
    logic                           any_set;

    logic                           n_res_found;
    logic [mlfq_pkg::LEVEL_W-1:0]   n_res_level;
    logic [mlfq_pkg::SLICE_W-1:0]   n_res_slice;
    logic                           n_res_resched;

    assign accept  = i_task.valid && i_task.ready;
    assign in_op   = mlfq_pkg::t_op'(i_task.operation);
    assign tid_x   = XW'(i_task.task_id);
    assign in_idx  = tid_x[TW-1:0];
    assign in_ok   = (32'(i_task.task_id) < MAX_TASKS);
    assign in_queued = in_ok ? r_queued[tid_x[QW-1:0]] : 1'b0;

    assign lv_sat  = (i_task.level > mlfq_pkg::TOP_LEVEL) ? mlfq_pkg::TOP_LEVEL : i_task.level;
    assign run_sat = (i_task.running_level > mlfq_pkg::TOP_LEVEL) ?
                     mlfq_pkg::TOP_LEVEL : i_task.running_level;
    assign dem_lv  = (lv_sat > mlfq_pkg::DEMOTE_STEP) ? (lv_sat - mlfq_pkg::DEMOTE_STEP) : '0;
    assign refill  = (dem_lv < mlfq_pkg::BAND_1_LOW) ? mlfq_pkg::SLICE_BAND_0 :
                     (dem_lv < mlfq_pkg::BAND_2_LOW) ? mlfq_pkg::SLICE_BAND_1 :
                                                       mlfq_pkg::SLICE_BAND_2;
    // A slice of zero counts as one, so it expires as well.
    assign expire  = i_task.is_timeshare && (i_task.slice_left <= mlfq_pkg::SLICE_ONE);

    always_comb begin
        in_alv    = lv_sat;
        in_append = 1'b0;
        case (in_op)
            mlfq_pkg::OP_ENQUEUE: begin
                in_alv    = i_task.wakeup ? mlfq_pkg::BOOST_TABLE[lv_sat] : lv_sat;
                in_append = in_ok;
            end
            mlfq_pkg::OP_YIELD: begin
                in_append = in_ok;
            end
            mlfq_pkg::OP_TICK: begin
                in_alv    = dem_lv;
                in_append = in_ok && expire;
            end
            default: begin
                in_append = 1'b0;
            end
        endcase
    end

    assign in_unlink = in_queued && (in_append || (in_op == mlfq_pkg::OP_DEQUEUE));

    // Result fields known at accept; the chosen task of a pick follows one read later.
    always_comb begin
        n_res_found   = 1'b0;
        n_res_level   = '0;
        n_res_slice   = '0;
        n_res_resched = 1'b0;
        case (in_op)
            mlfq_pkg::OP_ENQUEUE: begin
                n_res_level = in_alv;
            end
            mlfq_pkg::OP_PICK: begin
                n_res_found = any_set;
            end
            mlfq_pkg::OP_TICK: begin
                if (!i_task.is_timeshare) begin
                    n_res_level = lv_sat;
                    n_res_slice = i_task.slice_left;
                end else if (!expire) begin
                    n_res_level = lv_sat;
                    n_res_slice = i_task.slice_left - mlfq_pkg::SLICE_ONE;
                end else begin
                    n_res_level   = dem_lv;
                    n_res_slice   = refill;
                    n_res_resched = 1'b1;
                end
            end
            mlfq_pkg::OP_PREEMPT: begin
                n_res_resched = (lv_sat > run_sat);
            end
            default: begin
                n_res_found = 1'b0;
            end
        endcase
    end

    // Highest nonempty level; later iterations take priority.
    always_comb begin
        top_lv = '0;
        for (int i = 0; i < mlfq_pkg::NUM_LEVELS; i++) begin
            if (r_mask[i]) begin
                top_lv = mlfq_pkg::LEVEL_W'(i);
            end
        end
    end
    assign any_set = |r_mask;

    // ---------------------------------------------------------------- memories
    logic                           task_rd_en;
    logic [LW-1:0]                  td_next, td_prev;
    logic [mlfq_pkg::LEVEL_W-1:0]   td_level;
    mlfq_pkg::t_task_wen            task_wen;
    logic [TW-1:0]                  task_waddr;
    logic [LW-1:0]                  task_wnext, task_wprev;

    logic                           lvl_rd_en;
    logic [mlfq_pkg::LEVEL_W-1:0]   lvl_raddr;
    logic [TW-1:0]                  ld_head, ld_tail;
    mlfq_pkg::t_level_wen           lvl_wen;
    logic [mlfq_pkg::LEVEL_W-1:0]   lvl_waddr;
    logic [TW-1:0]                  lvl_whead, lvl_wtail;

    logic                           ap_bit;

    assign task_rd_en = accept;
    assign ap_bit     = r_mask[r_alv];

    // Reads of an entry are always issued after its last write and never together with a write,
    // so the sequence itself keeps the two memory ports apart.
    always_comb begin
        lvl_rd_en = 1'b0;
        lvl_raddr = r_alv;
        if (accept) begin
            lvl_rd_en = 1'b1;
            lvl_raddr = (in_op == mlfq_pkg::OP_PICK) ? top_lv : in_alv;
        end else if (r_state == S_UL_WR) begin
            lvl_rd_en = r_do_append;
        end
    end

    always_comb begin
        task_wen   = '0;
        task_waddr = r_idx;
        task_wnext = NONE;
        task_wprev = NONE;
        lvl_wen    = '0;
        lvl_waddr  = r_alv;
        lvl_whead  = r_idx;
        lvl_wtail  = r_idx;
        case (r_state)
            S_UL_RD: begin
                task_wen.next = (td_prev != NONE);
                task_waddr    = td_prev[TW-1:0];
                task_wnext    = td_next;
                lvl_waddr     = td_level;
                lvl_wen.head  = (td_prev == NONE);
                lvl_whead     = td_next[TW-1:0];
                lvl_wen.tail  = (td_next == NONE);
                lvl_wtail     = td_prev[TW-1:0];
            end
            S_UL_WR: begin
                task_wen.prev = (r_n != NONE);
                task_waddr    = r_n[TW-1:0];
                task_wprev    = r_p;
            end
            S_AP_WR: begin
                task_wen      = '{next: 1'b1, prev: 1'b1, level: 1'b1};
                task_wprev    = ap_bit ? LW'(ld_tail) : NONE;
                lvl_wen.head  = !ap_bit;
                lvl_wen.tail  = 1'b1;
            end
            S_AP_LINK: begin
                task_wen.next = 1'b1;
                task_waddr    = r_tl;
                task_wnext    = LW'(r_idx);
            end
            default: begin
                task_wen = '0;
            end
        endcase
    end

    mlfq_task_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (TW),
        .LW    (LW)
    ) u_task_mem (
        .i_clk      (i_clk),
        .i_rd_en    (task_rd_en),
        .i_rd_addr  (in_idx),
        .o_rd_next  (td_next),
        .o_rd_prev  (td_prev),
        .o_rd_level (td_level),
        .i_wr_en    (task_wen),
        .i_wr_addr  (task_waddr),
        .i_wr_next  (task_wnext),
        .i_wr_prev  (task_wprev),
        .i_wr_level (r_alv)
    );

    mlfq_level_mem #(
        .DW (TW)
    ) u_level_mem (
        .i_clk     (i_clk),
        .i_rd_en   (lvl_rd_en),
        .i_rd_addr (lvl_raddr),
        .o_rd_head (ld_head),
        .o_rd_tail (ld_tail),
        .i_wr_en   (lvl_wen),
        .i_wr_addr (lvl_waddr),
        .i_wr_head (lvl_whead),
        .i_wr_tail (lvl_wtail)
    );

    // ---------------------------------------------------------------- sequencer
    logic load_out;

    assign load_out = (r_state == S_FIN) && (!r_out_valid || o_result.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == mlfq_pkg::OP_PICK) begin
                        n_state = S_PK_RD;
                    end else if (in_unlink) begin
                        n_state = S_UL_RD;
                    end else if (in_append) begin
                        n_state = S_AP_WR;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_UL_RD:   n_state = S_UL_WR;
            S_UL_WR:   n_state = r_do_append ? S_AP_WR : S_FIN;
            S_AP_WR:   n_state = ap_bit ? S_AP_LINK : S_FIN;
            S_AP_LINK: n_state = S_FIN;
            S_PK_RD:   n_state = S_FIN;
            S_FIN:     n_state = load_out ? S_IDLE : S_FIN;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_queued    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_UL_RD) begin
                r_queued[r_idx[QW-1:0]] <= 1'b0;
                if (td_prev == NONE && td_next == NONE) begin
                    r_mask[td_level] <= 1'b0;
                end
            end
            if (r_state == S_AP_WR) begin
                r_queued[r_idx[QW-1:0]] <= 1'b1;
                r_mask[r_alv]           <= 1'b1;
            end
        end
    end

    // Item context and results; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx         <= in_idx;
            r_alv         <= in_alv;
            r_do_append   <= in_append;
            r_res_found   <= n_res_found;
            r_res_chosen  <= '0;
            r_res_level   <= n_res_level;
            r_res_slice   <= n_res_slice;
            r_res_resched <= n_res_resched;
        end
        if (r_state == S_UL_RD) begin
            r_p <= td_prev;
            r_n <= td_next;
        end
        if (r_state == S_AP_WR) begin
            r_tl <= ld_tail;
        end
        if (r_state == S_PK_RD) begin
            r_res_chosen <= r_res_found ? mlfq_pkg::TASK_W'(ld_head) : '0;
        end
        if (load_out) begin
            r_out_found   <= r_res_found;
            r_out_chosen  <= r_res_chosen;
            r_out_level   <= r_res_level;
            r_out_slice   <= r_res_slice;
            r_out_resched <= r_res_resched;
        end
    end

    assign i_task.ready         = (r_state == S_IDLE);
    assign o_result.valid       = r_out_valid;
    assign o_result.found       = r_out_found;
    assign o_result.chosen_task = r_out_chosen;
    assign o_result.new_level   = r_out_level;
    assign o_result.new_slice   = r_out_slice;
    assign o_result.resched     = r_out_resched;

    // ---------------------------------------------------------------- assertions
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start a sequence");

    a_append_sets_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AP_WR) |=> r_mask[$past(r_alv)])
        else $error("append left its level marked empty");

    a_unlink_clears_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UL_RD) |=> !r_queued[$past(r_idx[QW-1:0])])
        else $error("unlinked task still marked queued");

    a_link_needs_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AP_LINK) |-> r_mask[r_alv])
        else $error("tail link written for an empty level");

endmodule

`default_nettype wire
